[src/sct_pkg.sv]
// ----------------------------------------------------------------------------
// sct_pkg
// Types and constants shared by the sorted credential table and its testbench.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam logic [1:0]  ACT_CREATE = 2'd0;
    localparam logic [1:0]  ACT_AUTH   = 2'd1;
    localparam logic [1:0]  ACT_DELETE = 2'd2;

    localparam logic [13:0] ID_LIMIT   = 14'd9999;
    localparam logic [13:0] PASS_LOW   = 14'd1000;
    localparam logic [13:0] PASS_HIGH  = 14'd9999;
    localparam logic [2:0]  KIND_LIMIT = 3'd3;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_FULL       = 4'd1,
        ST_BAD_ID     = 4'd2,
        ST_BAD_PASS   = 4'd3,
        ST_EXISTS     = 4'd4,
        ST_BAD_TYPE   = 4'd5,
        ST_AUTH_OK    = 4'd6,
        ST_WRONG_PASS = 4'd7,
        ST_ABSENT     = 4'd8,
        ST_EMPTY      = 4'd9
    } t_status;

    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] user_id;
        logic [13:0] pass_code;
        logic [2:0]  user_kind;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  entry_count;
    } t_out_item;

    typedef struct packed {
        logic [13:0] id;
        logic [13:0] pass;
        logic [1:0]  kind;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_PROBE,
        S_HIT,
        S_DECIDE,
        S_UP,
        S_DOWN,
        S_FIN
    } t_state;

endpackage

[src/sct_ram.sv]
// ----------------------------------------------------------------------------
// sct_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sct_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/sorted_credential_table.sv]
// ----------------------------------------------------------------------------
// sorted_credential_table
// Credential table kept sorted by id in one RAM; binary search locates an id;
// create shifts entries from that slot up by one, delete those above it down.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//
//  One item at a time. After the checks, each binary search probe waits for the
//  registered RAM read data before it compares.
//  Create and delete move one entry per cycle through the single RAM port pair.
//  Reset clears the state and the entry count; no clearing pass over the RAM.
//  A stalled result waits in the output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module sorted_credential_table
    import sct_pkg::*;
#(
    parameter int MAX_USERS = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(MAX_USERS);
    localparam int CW = $clog2(MAX_USERS + 1);

    t_state          r_state, n_state;
    t_in_item        r_req;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW-1:0]   r_hi, n_hi;
    logic [CW-1:0]   r_mid, n_mid;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_count, n_count;
    logic            r_hit, n_hit;
    logic            r_pass_eq, n_pass_eq;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_wr_addr, n_wr_addr;
    t_status         r_status, n_status;
    logic            r_out_valid;
    t_out_item       r_out;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_entry          ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry          rd;

    logic [CW-1:0]   mid;
    logic [CW-1:0]   idx_dec;
    logic [CW-1:0]   idx_inc;
    logic            id_bad;
    logic            pass_bad;
    logic            fin_load;
    t_entry          new_entry;

    assign rd        = t_entry'(ram_rdata);
    assign mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign idx_dec   = r_idx - CW'(1);
    assign idx_inc   = r_idx + CW'(1);
    assign id_bad    = r_req.user_id > ID_LIMIT;
    assign pass_bad  = (r_req.pass_code < PASS_LOW) || (r_req.pass_code > PASS_HIGH);
    assign fin_load  = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign new_entry = '{id: r_req.user_id, pass: r_req.pass_code,
                         kind: r_req.user_kind[1:0]};

    sct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_USERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                unique case (r_req.action)
                    ACT_CREATE: begin
                        n_state = (r_count >= CW'(MAX_USERS) || id_bad || pass_bad)
                                  ? S_FIN : S_SEARCH;
                    end
                    ACT_AUTH: begin
                        n_state = (id_bad || pass_bad) ? S_FIN : S_SEARCH;
                    end
                    ACT_DELETE: begin
                        n_state = (r_count == '0) ? S_FIN : S_SEARCH;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SEARCH: begin
                priority if (r_lo < r_hi) begin
                    n_state = S_PROBE;
                end else if (r_lo < r_count) begin
                    n_state = S_HIT;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_PROBE: n_state = S_SEARCH;
            S_HIT:   n_state = S_DECIDE;
            S_DECIDE: begin
                n_state = S_FIN;
                if (r_hit && r_req.action == ACT_DELETE) begin
                    n_state = S_DOWN;
                end else if (!r_hit && r_req.action == ACT_CREATE
                             && r_req.user_kind <= KIND_LIMIT) begin
                    n_state = S_UP;
                end
            end
            S_UP: begin
                if (r_idx == r_lo && !r_pend) begin
                    n_state = S_FIN;
                end
            end
            S_DOWN: begin
                if (idx_inc >= r_count && !r_pend) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        ram_we     = 1'b0;
        ram_waddr  = r_wr_addr;
        ram_wdata  = rd;
        ram_raddr  = mid[AW-1:0];
        unique case (r_state)
            S_SEARCH: begin
                ram_raddr = (r_lo < r_hi) ? mid[AW-1:0] : r_lo[AW-1:0];
            end
            S_UP: begin
                ram_raddr = idx_dec[AW-1:0];
                if (r_pend) begin
                    ram_we = 1'b1;
                end else if (r_idx == r_lo) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lo[AW-1:0];
                    ram_wdata = new_entry;
                end
            end
            S_DOWN: begin
                ram_raddr = idx_inc[AW-1:0];
                ram_we    = r_pend;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_idx     = r_idx;
        n_count   = r_count;
        n_hit     = r_hit;
        n_pass_eq = r_pass_eq;
        n_pend    = r_pend;
        n_wr_addr = r_wr_addr;
        n_status  = r_status;
        unique case (r_state)
            S_CHECK: begin
                n_lo = '0;
                n_hi = r_count;
                unique case (r_req.action)
                    ACT_CREATE: begin
                        priority if (r_count >= CW'(MAX_USERS)) n_status = ST_FULL;
                        else if (id_bad)                        n_status = ST_BAD_ID;
                        else if (pass_bad)                      n_status = ST_BAD_PASS;
                        else                                    n_status = ST_OK;
                    end
                    ACT_AUTH: begin
                        priority if (id_bad)  n_status = ST_BAD_ID;
                        else if (pass_bad)    n_status = ST_BAD_PASS;
                        else                  n_status = ST_OK;
                    end
                    ACT_DELETE: begin
                        n_status = (r_count == '0) ? ST_EMPTY : ST_OK;
                    end
                    default: n_status = ST_BAD_TYPE;
                endcase
            end
            S_SEARCH: begin
                n_mid = mid;
                n_hit = 1'b0;
            end
            S_PROBE: begin
                if (rd.id < r_req.user_id) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
            end
            S_HIT: begin
                n_hit     = (rd.id == r_req.user_id);
                n_pass_eq = (rd.pass == r_req.pass_code);
            end
            S_DECIDE: begin
                n_pend = 1'b0;
                unique case (r_req.action)
                    ACT_CREATE: begin
                        n_idx = r_count;
                        priority if (r_hit)                      n_status = ST_EXISTS;
                        else if (r_req.user_kind > KIND_LIMIT)   n_status = ST_BAD_TYPE;
                        else                                     n_status = ST_OK;
                    end
                    ACT_AUTH: begin
                        priority if (!r_hit) n_status = ST_ABSENT;
                        else if (r_pass_eq)  n_status = ST_AUTH_OK;
                        else                 n_status = ST_WRONG_PASS;
                    end
                    default: begin
                        n_idx    = r_lo;
                        n_status = r_hit ? ST_OK : ST_ABSENT;
                    end
                endcase
            end
            S_UP: begin
                if (r_idx != r_lo) begin
                    n_pend    = 1'b1;
                    n_wr_addr = r_idx[AW-1:0];
                    n_idx     = idx_dec;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            S_DOWN: begin
                if (idx_inc < r_count) begin
                    n_pend    = 1'b1;
                    n_wr_addr = r_idx[AW-1:0];
                    n_idx     = idx_inc;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req <= i_in_data;
        end
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_idx     <= n_idx;
        r_hit     <= n_hit;
        r_pass_eq <= n_pass_eq;
        r_wr_addr <= n_wr_addr;
        r_status  <= n_status;
        if (fin_load) begin
            r_out <= '{status: r_status, entry_count: 8'(r_count)};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_USERS))
        else $error("entry count above table size");

    a_write_in_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_UP || r_state == S_DOWN))
        else $error("RAM write outside a shift");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count))
        |-> ($past(r_state) == S_UP || $past(r_state) == S_DOWN))
        else $error("entry count changed outside a shift");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_lo <= r_hi && r_hi <= r_count))
        else $error("search window out of range");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result issued outside finish");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted credential table. A directed opening hits
// every status code except ST_FULL, and the field limits. Random phases then
// alternately favour creates to grow the table and deletes to shrink it. Each
// accepted item is run through a local model of the sorted table, and every
// result is compared with the oldest outstanding prediction. The sender idles in
// bursts, and the receiver stalls on its own schedule, including one long
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
    import sct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH    = 128;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_START     = 300;
    localparam int HOLD_CYCLES    = 600;

    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam int STALL_NONE  = 0;
    localparam int STALL_LIGHT = 1;
    localparam int STALL_HEAVY = 2;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    sorted_credential_table #(
        .MAX_USERS(TABLE_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    logic [13:0] ledger_id   [TABLE_DEPTH];
    logic [13:0] ledger_pass [TABLE_DEPTH];
    logic [1:0]  ledger_kind [TABLE_DEPTH];
    int          ledger_count = 0;

    t_in_item    request_queue[$];
    t_out_item   pending_outcomes[$];
    int          known_ids[$];
    logic [13:0] known_pass[int];

    int total_items  = 0;
    int items_taken  = 0;
    int error_count  = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int stall_mode   = STALL_NONE;
    int hold_count   = 0;
    bit hold_done    = 1'b0;
    int idle_cycles  = 0;

    function automatic bit pass_in_range(logic [13:0] code);
        return code >= PASS_LOW && code <= PASS_HIGH;
    endfunction

    function automatic int lower_slot(logic [13:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = ledger_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (ledger_id[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic t_out_item apply_request(t_in_item req);
        t_out_item res;
        t_status   st;
        int        slot;
        int        i;
        bit        found;
        slot  = lower_slot(req.user_id);
        found = slot < ledger_count && ledger_id[slot] == req.user_id;
        case (req.action)
            ACT_CREATE: begin
                if (ledger_count >= TABLE_DEPTH) begin
                    st = ST_FULL;
                end else if (req.user_id > ID_LIMIT) begin
                    st = ST_BAD_ID;
                end else if (!pass_in_range(req.pass_code)) begin
                    st = ST_BAD_PASS;
                end else if (found) begin
                    st = ST_EXISTS;
                end else if (req.user_kind > KIND_LIMIT) begin
                    st = ST_BAD_TYPE;
                end else begin
                    for (i = ledger_count; i > slot; i--) begin
                        ledger_id[i]   = ledger_id[i - 1];
                        ledger_pass[i] = ledger_pass[i - 1];
                        ledger_kind[i] = ledger_kind[i - 1];
                    end
                    ledger_id[slot]   = req.user_id;
                    ledger_pass[slot] = req.pass_code;
                    ledger_kind[slot] = req.user_kind[1:0];
                    ledger_count++;
                    st = ST_OK;
                end
            end
            ACT_AUTH: begin
                if (req.user_id > ID_LIMIT) begin
                    st = ST_BAD_ID;
                end else if (!pass_in_range(req.pass_code)) begin
                    st = ST_BAD_PASS;
                end else if (!found) begin
                    st = ST_ABSENT;
                end else if (ledger_pass[slot] == req.pass_code) begin
                    st = ST_AUTH_OK;
                end else begin
                    st = ST_WRONG_PASS;
                end
            end
            ACT_DELETE: begin
                if (ledger_count == 0) begin
                    st = ST_EMPTY;
                end else if (!found) begin
                    st = ST_ABSENT;
                end else begin
                    for (i = slot; i + 1 < ledger_count; i++) begin
                        ledger_id[i]   = ledger_id[i + 1];
                        ledger_pass[i] = ledger_pass[i + 1];
                        ledger_kind[i] = ledger_kind[i + 1];
                    end
                    ledger_count--;
                    st = ST_OK;
                end
            end
            default: begin
                st = ST_BAD_TYPE;
            end
        endcase
        res.status      = st;
        res.entry_count = ledger_count[7:0];
        return res;
    endfunction

    task automatic queue_request(input logic [1:0] action, input logic [13:0] user_id,
                                 input logic [13:0] pass_code, input logic [2:0] user_kind);
        t_in_item req;
        req.action    = action;
        req.user_id   = user_id;
        req.pass_code = pass_code;
        req.user_kind = user_kind;
        if (action == ACT_CREATE && user_id <= ID_LIMIT && !known_pass.exists(int'(user_id)))
        begin
            known_pass[int'(user_id)] = pass_code;
            known_ids.push_back(int'(user_id));
        end
        request_queue.push_back(req);
    endtask

    task automatic queue_random(input int create_pct);
        logic [1:0]  action;
        logic [13:0] user_id;
        logic [13:0] pass_code;
        logic [2:0]  user_kind;
        bit          use_known;
        if ($urandom_range(99) < 8) begin
            queue_request(2'($urandom_range(3)), 14'($urandom_range(16383)),
                          14'($urandom_range(16383)), 3'($urandom_range(7)));
        end else begin
            if ($urandom_range(99) < create_pct) begin
                action    = ACT_CREATE;
                use_known = known_ids.size() > 0 && $urandom_range(99) < 20;
            end else begin
                action    = ($urandom_range(99) < 55) ? ACT_DELETE : ACT_AUTH;
                use_known = known_ids.size() > 0 && $urandom_range(99) < 85;
            end
            user_id   = use_known ? 14'(known_ids[$urandom_range(known_ids.size() - 1)])
                                  : 14'($urandom_range(ID_LIMIT));
            pass_code = 14'($urandom_range(PASS_HIGH, PASS_LOW));
            if (action == ACT_AUTH && known_pass.exists(int'(user_id))
                && $urandom_range(99) < 70) begin
                pass_code = known_pass[int'(user_id)];
            end
            user_kind = ($urandom_range(99) < 95) ? 3'($urandom_range(3))
                                                  : 3'($urandom_range(7, 4));
            queue_request(action, user_id, pass_code, user_kind);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pending_outcomes.push_back(apply_request(i_in_data));
                items_taken <= items_taken + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= request_queue.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(40, 1);
                        gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (!hold_done && items_taken >= HOLD_START) begin
            if (hold_count < HOLD_CYCLES) begin
                hold_count  <= hold_count + 1;
                i_out_stall <= 1'b1;
            end else begin
                hold_done   <= 1'b1;
                i_out_stall <= 1'b0;
            end
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(STALL_HEAVY, STALL_NONE);
                stall_left <= $urandom_range(200, 20);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                STALL_LIGHT: i_out_stall <= ($urandom_range(99) < 30);
                STALL_HEAVY: i_out_stall <= ($urandom_range(99) < 75);
                default:     i_out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result: status %0d, count %0d",
                         $time, o_out_data.status, o_out_data.entry_count);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_out_data.status);
                    error_count++;
                end
                if (o_out_data.entry_count !== want.entry_count) begin
                    $display("%0t: entry count mismatch: expected %0d, actual %0d",
                             $time, want.entry_count, o_out_data.entry_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("sorted_credential_table test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        queue_request(ACT_DELETE, 14'd5,     14'd1234,  3'd0);
        queue_request(ACT_AUTH,   14'd5,     14'd1234,  3'd0);
        queue_request(ACT_CREATE, 14'd16383, 14'd1234,  3'd0);
        queue_request(ACT_CREATE, 14'd10000, 14'd1234,  3'd0);
        queue_request(ACT_CREATE, 14'd0,     14'd999,   3'd0);
        queue_request(ACT_CREATE, 14'd0,     14'd10000, 3'd0);
        queue_request(ACT_CREATE, 14'd0,     14'd16383, 3'd7);
        queue_request(ACT_CREATE, 14'd0,     14'd1000,  3'd4);
        queue_request(ACT_CREATE, 14'd0,     14'd1000,  3'd0);
        queue_request(ACT_CREATE, 14'd9999,  14'd9999,  3'd1);
        queue_request(ACT_CREATE, 14'd5000,  14'd4321,  3'd2);
        queue_request(ACT_CREATE, 14'd9999,  14'd1000,  3'd7);
        queue_request(ACT_CREATE, 14'd2500,  14'd2500,  3'd3);
        queue_request(ACT_AUTH,   14'd5000,  14'd4321,  3'd0);
        queue_request(ACT_AUTH,   14'd5000,  14'd4322,  3'd0);
        queue_request(ACT_AUTH,   14'd4999,  14'd4321,  3'd0);
        queue_request(ACT_AUTH,   14'd16383, 14'd4321,  3'd0);
        queue_request(ACT_AUTH,   14'd0,     14'd0,     3'd0);
        queue_request(ACT_DELETE, 14'd16383, 14'd0,     3'd0);
        queue_request(ACT_DELETE, 14'd9999,  14'd0,     3'd0);
        queue_request(ACT_SPARE,  14'd16383, 14'd16383, 3'd7);
        queue_request(ACT_DELETE, 14'd0,     14'd0,     3'd0);
        queue_request(ACT_AUTH,   14'd0,     14'd1000,  3'd0);
        queue_request(ACT_CREATE, 14'd1,     14'd5555,  3'd6);
        for (int phase = 0; phase < 6; phase++) begin
            for (int n = 0; n < 190; n++) begin
                queue_random((phase % 2 == 0) ? 85 : 10);
            end
        end
        total_items = request_queue.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken < total_items || pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("sorted_credential_table test passed");
        end else begin
            $display("sorted_credential_table test failed");
        end
        $finish;
    end

endmodule
